// ----- design/pcp_pkg.sv -----
// package for the prefix code bit packer: widths, defaults and op codes
`timescale 1ns / 1ps

package pcp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam int SYM_W      = 8;
    localparam int CODE_W     = 32;
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int MAX_BYTES  = 4;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;

    typedef enum logic [S_TUSER_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

endpackage

// ----- design/prefix_code_bit_packer.sv -----
// top level: table-driven prefix code encoder with msb-first byte packer
//
// channel | direction | tdata (low bit up)                          | tuser | tlast
// --------+-----------+---------------------------------------------+-------+------------------
// s       | in        | symbol[7:0], code_bits[39:8], code_length[45:40] | op    | -
// m       | out       | packed_byte[7:0]                            | -     | last_of_run
//
// an input transaction can be taken every cycle while stage 1 is empty or moving on; the code
// table ram is read at accept into its registered read data, stage 1 combines that data with
// the pending byte, and the result is registered in a result buffer. one item may yield up to
// four bytes, drained one per cycle while the sink is ready, so input stalls only while that buffer is still draining.
// reset (synchronous, active low) clears per-entry valid bits, so the table needs no
// clearing pass; the ram contents stay undefined until each entry is loaded.
`timescale 1ns / 1ps

module prefix_code_bit_packer #(
    parameter int MAX_CODE_LEN = pcp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = pcp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // symbol, code_bits, code_length, two zero pad bits
    input  logic [pcp_pkg::S_TDATA_W-1:0] i_s_tdata,
    // op
    input  logic [pcp_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // packed_byte
    output logic [pcp_pkg::BYTE_W-1:0]    o_m_tdata,
    output logic                          o_m_tlast
);

    import pcp_pkg::*;

    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int TAB_AW    = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W   = CODE_W + LEN_W;
    localparam int WIN_W     = CODE_W + BYTE_W;

    // input unpack
    logic [SYM_W-1:0]  s_symbol;
    logic [CODE_W-1:0] s_code_bits;
    logic [LEN_W-1:0]  s_code_length;
    logic [LEN_W-1:0]  s_len_sat;
    logic              s_accept;
    logic              s_in_range;
    logic [TAB_AW-1:0] s_addr;
    logic              s_load_we;

    assign s_symbol      = i_s_tdata[SYM_W-1:0];
    assign s_code_bits   = i_s_tdata[SYM_W +: CODE_W];
    assign s_code_length = i_s_tdata[SYM_W+CODE_W +: LEN_W];
    assign s_accept      = i_s_tvalid & o_s_tready;
    assign s_in_range    = ({1'b0, s_symbol} < (SYM_W+1)'(SYMBOL_COUNT));
    assign s_addr        = s_symbol[TAB_AW-1:0];
    assign s_len_sat     = (s_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                               : s_code_length;
    assign s_load_we     = s_accept && (t_op'(i_s_tuser) == OP_LOAD) && s_in_range;

    // code table
    logic [ENTRY_W-1:0] tab_rdata;

    pcp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (s_load_we),
        .i_waddr (s_addr),
        .i_wdata ({s_code_bits, s_len_sat}),
        .i_re    (s_accept),
        .i_raddr (s_addr),
        .o_rdata (tab_rdata)
    );

    // entry valid bits, cleared at reset
    logic [SYMBOL_COUNT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_load_we) begin
            r_vld[s_addr] <= 1'b1;
        end
    end

    // stage 1: item waiting on table data
    logic                 r_s1_vld;
    logic [S_TUSER_W-1:0] r_s1_op;
    logic                 r_s1_hit;

    // pending partial byte
    logic [BYTE_W-1:0] r_pb;
    logic [2:0]        r_pc;
    logic [BYTE_W-1:0] n_pb;
    logic [2:0]        n_pc;

    // result buffer
    logic [BYTE_W-1:0] r_bq [MAX_BYTES];
    logic [1:0]        r_bq_idx;
    logic [2:0]        r_bq_cnt;

    // combine logic
    logic [CODE_W-1:0] s1_code;
    logic [LEN_W-1:0]  s1_len;
    logic [CODE_W-1:0] s1_code_lj;
    logic [WIN_W-1:0]  s1_win;
    logic [LEN_W:0]    s1_total;
    logic [2:0]        s1_nres;
    logic [BYTE_W-1:0] s1_bytes [MAX_BYTES];
    logic              bq_done;
    logic              s1_go;
    logic              m_accept;

    always_comb begin
        s1_code    = tab_rdata[LEN_W +: CODE_W];
        s1_len     = ((t_op'(r_s1_op) == OP_ENCODE) && r_s1_hit) ? tab_rdata[LEN_W-1:0]
                                                                 : '0;
        // left-justify the code so its first bit lands in the msb
        s1_code_lj = s1_code << ((LEN_W+1)'(CODE_W) - {1'b0, s1_len});
        s1_win     = {r_pb, {CODE_W{1'b0}}} | ({s1_code_lj, {BYTE_W{1'b0}}} >> r_pc);
        s1_total   = {{(LEN_W-2){1'b0}}, r_pc} + {1'b0, s1_len};
        for (int k = 0; k < MAX_BYTES; k++) begin
            s1_bytes[k] = s1_win[WIN_W-1-BYTE_W*k -: BYTE_W];
        end
        s1_nres = '0;
        n_pb    = r_pb;
        n_pc    = r_pc;
        unique case (t_op'(r_s1_op))
            OP_ENCODE: begin
                s1_nres = s1_total[5:3];
                n_pc    = s1_total[2:0];
                unique case (s1_total[5:3])
                    3'd0:    n_pb = s1_win[WIN_W-1 -: BYTE_W];
                    3'd1:    n_pb = s1_win[WIN_W-1-BYTE_W -: BYTE_W];
                    3'd2:    n_pb = s1_win[WIN_W-1-2*BYTE_W -: BYTE_W];
                    3'd3:    n_pb = s1_win[WIN_W-1-3*BYTE_W -: BYTE_W];
                    default: n_pb = s1_win[WIN_W-1-4*BYTE_W -: BYTE_W];
                endcase
            end
            OP_FLUSH: begin
                if (r_pc != 3'd0) begin
                    s1_nres     = 3'd1;
                    s1_bytes[0] = r_pb;
                end
                n_pb = '0;
                n_pc = '0;
            end
            default: begin
                s1_nres = '0;
            end
        endcase
    end

    assign m_accept   = o_m_tvalid & i_m_tready;
    assign bq_done    = (r_bq_cnt == 3'd0) || ((r_bq_cnt == 3'd1) && i_m_tready);
    assign s1_go      = r_s1_vld && ((s1_nres == 3'd0) || bq_done);
    assign o_s_tready = !r_s1_vld || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_pb     <= '0;
            r_pc     <= '0;
            r_bq_cnt <= '0;
            r_bq_idx <= '0;
        end else begin
            if (s_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_pb <= n_pb;
                r_pc <= n_pc;
            end
            if (s1_go && (s1_nres != 3'd0)) begin
                r_bq_cnt <= s1_nres;
                r_bq_idx <= '0;
            end else if (m_accept) begin
                r_bq_cnt <= r_bq_cnt - 3'd1;
                r_bq_idx <= r_bq_idx + 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_op  <= i_s_tuser;
            r_s1_hit <= s_in_range && r_vld[s_addr];
        end
        if (s1_go && (s1_nres != 3'd0)) begin
            for (int k = 0; k < MAX_BYTES; k++) begin
                r_bq[k] <= s1_bytes[k];
            end
        end
    end

    assign o_m_tvalid = (r_bq_cnt != 3'd0);
    assign o_m_tdata  = r_bq[r_bq_idx];
    assign o_m_tlast  = (r_bq_cnt == 3'd1);

endmodule

// ----- design/pcp_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module pcp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sim/pcp_stream_checker.sv -----
// stream checker for the prefix code bit packer: code table predictor and byte compare
`timescale 1ns / 1ps

module pcp_stream_checker #(
    parameter int MAX_CODE_LEN = pcp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = pcp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // symbol, code_bits, code_length, two zero pad bits
    input  logic [pcp_pkg::S_TDATA_W-1:0] i_s_tdata,
    // op
    input  logic [pcp_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // packed_byte
    input  logic [pcp_pkg::BYTE_W-1:0]    i_m_tdata,
    input  logic                          i_m_tlast,
    output int                            o_mismatch_count,
    output int                            o_outstanding
);

    import pcp_pkg::*;

    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_byte;

    logic [CODE_W-1:0] code_of_sym [SYMBOL_COUNT];
    logic [LEN_W-1:0]  len_of_sym  [SYMBOL_COUNT];
    logic [BYTE_W-1:0] partial_byte;
    int                partial_bits;
    t_out_byte         expected_bytes [$];

    initial begin
        o_mismatch_count = 0;
        o_outstanding    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_mismatch_count++;
    endtask

    task automatic clear_model();
        for (int s = 0; s < SYMBOL_COUNT; s++) begin
            code_of_sym[s] = '0;
            len_of_sym[s]  = '0;
        end
        partial_byte = '0;
        partial_bits = 0;
        expected_bytes.delete();
    endtask

    // appends the table code of one symbol, msb first, and queues every byte it completes
    task automatic pack_symbol_code(input int sym);
        logic [BYTE_W-1:0] run [MAX_BYTES];
        logic [CODE_W-1:0] code;
        int                clen;
        int                n;
        t_out_byte         ob;
        n = 0;
        if (sym >= SYMBOL_COUNT) return;
        code = code_of_sym[sym];
        clen = len_of_sym[sym];
        if (clen > CODE_W) clen = CODE_W;
        for (int i = clen; i > 0; i--) begin
            if (code[i-1]) partial_byte[7 - partial_bits] = 1'b1;
            if (partial_bits == 7) begin
                if (n < MAX_BYTES) begin
                    run[n] = partial_byte;
                    n++;
                end
                partial_byte = '0;
                partial_bits = 0;
            end else begin
                partial_bits++;
            end
        end
        for (int k = 0; k < n; k++) begin
            ob.data = run[k];
            ob.last = (k == n - 1);
            expected_bytes.push_back(ob);
        end
    endtask

    task automatic predict_transaction(input logic [S_TDATA_W-1:0] data,
                                       input logic [S_TUSER_W-1:0] op);
        int                sym;
        logic [CODE_W-1:0] code;
        int                len;
        t_out_byte         ob;
        sym  = data[7:0];
        code = data[39:8];
        len  = data[45:40];
        case (op)
            OP_LOAD: begin
                if (sym < SYMBOL_COUNT) begin
                    if (len > LEN_CAP) len = LEN_CAP;
                    code_of_sym[sym] = code;
                    len_of_sym[sym]  = len[LEN_W-1:0];
                end
            end
            OP_ENCODE: begin
                pack_symbol_code(sym);
            end
            OP_FLUSH: begin
                if (partial_bits > 0) begin
                    ob.data = partial_byte;
                    ob.last = 1'b1;
                    expected_bytes.push_back(ob);
                    partial_byte = '0;
                    partial_bits = 0;
                end
            end
            default: begin
                // reserved op leaves everything alone
            end
        endcase
    endtask

    task automatic check_byte(input logic [BYTE_W-1:0] data, input logic last);
        t_out_byte want;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %b", data, last));
            return;
        end
        want = expected_bytes.pop_front();
        if (data !== want.data)
            report_mismatch($sformatf("packed_byte %02h, want %02h", data, want.data));
        if (last !== want.last)
            report_mismatch($sformatf("last_of_run %b, want %b (byte %02h)",
                                      last, want.last, want.data));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_m_tvalid && i_m_tready) check_byte(i_m_tdata, i_m_tlast);
            if (i_s_tvalid && i_s_tready) predict_transaction(i_s_tdata, i_s_tuser);
        end
        o_outstanding <= expected_bytes.size();
    end

endmodule

// ----- sim/prefix_code_bit_packer_tb.sv -----
// testbench top for the prefix code bit packer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module prefix_code_bit_packer_tb;
    import pcp_pkg::*;

    localparam logic [S_TUSER_W-1:0] OP_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 390;
    localparam int SETTLE_CYCLES = 20;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic [S_TUSER_W-1:0] i_s_tuser  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [BYTE_W-1:0]    o_m_tdata;
    logic                 o_m_tlast;

    int   mismatch_count;
    int   bytes_outstanding;
    logic calm = 1'b0;
    logic [7:0] loaded_syms [$];

    prefix_code_bit_packer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    pcp_stream_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_s_tuser        (i_s_tuser),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tlast        (o_m_tlast),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (bytes_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // byte sink with a random stall ahead of every transaction, none while calm
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid === 1'b1 && i_m_tready));
        end
    end

    task automatic send_item(input logic [S_TUSER_W-1:0] op, input logic [7:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, len, code, sym};
        i_s_tuser  <= op;
        if (op == OP_LOAD) loaded_syms.push_back(sym);
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
    endtask

    // hold the input side until every predicted byte has come out
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (bytes_outstanding != 0);
    endtask

    task automatic send_random_item();
        int               r;
        logic [7:0]       sym;
        logic [LEN_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 19))
                0:       len = 6'd0;
                1, 2:    len = 6'($urandom_range(33, 63));
                3, 4, 5: len = 6'($urandom_range(11, 32));
                default: len = 6'($urandom_range(1, 10));
            endcase
            send_item(OP_LOAD, 8'($urandom), $urandom, len);
        end else if (r < 87) begin
            if (loaded_syms.size() != 0 && $urandom_range(0, 9) != 0)
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            else
                sym = 8'($urandom);
            send_item(OP_ENCODE, sym, $urandom, 6'($urandom));
        end else if (r < 97) begin
            send_item(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom));
        end else begin
            send_item(OP_RESERVED, 8'($urandom), $urandom, 6'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table entry and flush with nothing pending
        send_item(OP_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'h3F);
        send_item(OP_FLUSH,  8'hFF, 32'h0000_0000, 6'h00);
        // full-length all-ones code gives four bytes from one symbol
        send_item(OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        // one-bit code, upper code bits ignored
        send_item(OP_LOAD,   8'h00, 32'hFFFF_FFFE, 6'd1);
        send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_item(OP_FLUSH,  8'h00, 32'h0, 6'd0);
        wait_drained();
        // overlong lengths saturate at 32
        send_item(OP_LOAD,   8'hA5, 32'hA5A5_A5A5, 6'h3F);
        send_item(OP_ENCODE, 8'hA5, 32'h0, 6'd0);
        send_item(OP_LOAD,   8'h22, 32'h1234_5678, 6'd33);
        send_item(OP_ENCODE, 8'h22, 32'h0, 6'd0);
        // seven-bit code steps the pending count through 7, 6 and 5
        send_item(OP_LOAD,   8'h5A, 32'hFFFF_FF5A, 6'd7);
        send_item(OP_ENCODE, 8'h5A, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'h5A, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'h5A, 32'h0, 6'd0);
        // reserved op with every field high
        send_item(OP_RESERVED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        // zero length clears an entry even with code bits set
        send_item(OP_LOAD,   8'h11, 32'hDEAD_BEEF, 6'd0);
        send_item(OP_ENCODE, 8'h11, 32'h0, 6'd0);
        send_item(OP_LOAD,   8'hFF, 32'h0000_0000, 6'd32);
        send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        send_item(OP_FLUSH,  8'h00, 32'h0, 6'd0);
        send_item(OP_FLUSH,  8'h00, 32'h0, 6'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2) wait_drained();
            send_random_item();
        end

        calm = 1'b1;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && bytes_outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pcp_pkg.sv
design/pcp_ram.sv
design/prefix_code_bit_packer.sv
sim/pcp_stream_checker.sv
sim/prefix_code_bit_packer_tb.sv
